// ===== design/nntu_pkg.sv =====
package nntu_pkg;

	localparam int NET_SLOTS_DEF  = 16;
	localparam int NODE_SLOTS_DEF = 64;
	localparam int CH_LO          = 11;
	localparam int CH_HI          = 26;

	localparam logic [2:0] ST_NEW_NODE  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_NET_DROP  = 3'd2;
	localparam logic [2:0] ST_NODE_DROP = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	localparam logic OP_SIGHT = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        hit;
		logic        fresh;
		logic [15:0] mask;
		logic [6:0]  cnt;
	} net_tok_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic fresh;
	} node_tok_t;

	typedef struct packed {
		logic [15:0] id;
		logic [3:0]  proto;
		logic [15:0] chbit;
		logic [7:0]  sig;
		logic [7:0]  lq;
	} net_query_t;

	typedef struct packed {
		logic [15:0] net;
		logic [15:0] sa;
		logic        has_s;
		logic [63:0] la;
		logic        has_l;
		logic [47:0] metrics;
	} node_query_t;

endpackage

// ===== design/network_node_table_upsert_unit.sv =====
// Sighting table: a sighting walks a chain of network cells (one cell per cycle) and then a
// chain of node cells; a sighting dropped for a full network table skips the node chain.
// The result is held in an output register, and a new transaction may be taken while
// it waits.
module network_node_table_upsert_unit #(
	parameter int NET_SLOTS  = nntu_pkg::NET_SLOTS_DEF,
	parameter int NODE_SLOTS = nntu_pkg::NODE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [15:0] network_id,
	input  logic [3:0]  protocol_code,
	input  logic [4:0]  channel,
	input  logic [15:0] short_address,
	input  logic        short_present,
	input  logic [63:0] long_address,
	input  logic        long_present,
	input  logic signed [7:0] signal_strength,
	input  logic [7:0]  link_quality,
	input  logic [31:0] seen_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        first_sighting,
	output logic [31:0] dropped_total,
	output logic [6:0]  network_node_count,
	output logic [15:0] network_channel_mask
);
	localparam int NETCW  = $clog2(NET_SLOTS + 1);
	localparam int NODECW = $clog2(NODE_SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_NET  = 4'b0010,
		S_NODE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [NETCW-1:0]  net_count_q;
	logic [NODECW-1:0] node_count_q;
	logic [31:0]       drop_q;
	nntu_pkg::net_query_t  nq_q;
	nntu_pkg::node_query_t dq_q;
	logic [2:0]  res_status_q;
	logic        res_first_q;
	logic [6:0]  res_cnt_q;
	logic [15:0] res_mask_q;
	logic        commit_inc;
	logic        accept;
	logic        net_start, node_start;
	logic        net_go_q;
	logic [4:0]  choff;

	nntu_pkg::net_tok_t  net_tok  [0:NET_SLOTS];
	nntu_pkg::node_tok_t node_tok [0:NODE_SLOTS];

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign choff    = channel - 5'(nntu_pkg::CH_LO);
	assign net_start = accept && (operation == nntu_pkg::OP_SIGHT);
	assign node_start = (state_q == S_NET) && net_tok[NET_SLOTS].valid && net_tok[NET_SLOTS].hit;

	assign net_tok[0] = '{valid: net_go_q, hit: 1'b0, fresh: 1'b0, mask: 16'd0, cnt: 7'd0};
	assign node_tok[0] = '{valid: node_start, hit: 1'b0, fresh: 1'b0};
	assign commit_inc = (state_q == S_NODE) && node_tok[NODE_SLOTS].valid
		&& node_tok[NODE_SLOTS].fresh;

	for (genvar i = 0; i < NET_SLOTS; i++) begin : g_net
		nntu_net_cell #(.IDX(i), .CW(NETCW), .NCW(NODECW)) u_cell (
			.clk, .arst_n,
			.tok_in(net_tok[i]), .qry(nq_q), .count(net_count_q),
			.commit_inc, .tok_out(net_tok[i+1])
		);
	end

	for (genvar i = 0; i < NODE_SLOTS; i++) begin : g_node
		nntu_node_cell #(.IDX(i), .CW(NODECW)) u_cell (
			.clk, .arst_n,
			.tok_in(node_tok[i]), .qry(dq_q), .count(node_count_q),
			.tok_out(node_tok[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nq_q.id    <= network_id;
			nq_q.proto <= protocol_code;
			nq_q.chbit <= (channel >= 5'(nntu_pkg::CH_LO) && channel <= 5'(nntu_pkg::CH_HI))
				? (16'd1 << choff[3:0]) : 16'd0;
			nq_q.sig   <= signal_strength;
			nq_q.lq    <= link_quality;
			dq_q.net   <= network_id;
			dq_q.sa    <= short_address;
			dq_q.has_s <= short_present;
			dq_q.la    <= long_address;
			dq_q.has_l <= long_present;
			dq_q.metrics <= {signal_strength, link_quality, seen_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= (state_q == S_DONE) || (out_valid && !out_ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			net_go_q     <= 1'b0;
			net_count_q  <= '0;
			node_count_q <= '0;
			drop_q       <= '0;
			res_status_q <= nntu_pkg::ST_CLEARED;
			res_first_q  <= 1'b0;
			res_cnt_q    <= '0;
			res_mask_q   <= '0;
			status       <= '0;
			first_sighting <= 1'b0;
			dropped_total  <= '0;
			network_node_count   <= '0;
			network_channel_mask <= '0;
		end else begin
			net_go_q <= net_start;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == nntu_pkg::OP_CLEAR) begin
							net_count_q  <= '0;
							node_count_q <= '0;
							drop_q       <= '0;
							res_status_q <= nntu_pkg::ST_CLEARED;
							res_first_q  <= 1'b0;
							res_cnt_q    <= '0;
							res_mask_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_NET;
						end
					end
				end
				S_NET: begin
					if (net_tok[NET_SLOTS].valid) begin
						if (!net_tok[NET_SLOTS].hit) begin
							drop_q       <= drop_q + 32'd1;
							res_status_q <= nntu_pkg::ST_NET_DROP;
							res_first_q  <= 1'b0;
							res_cnt_q    <= '0;
							res_mask_q   <= '0;
							state_q      <= S_DONE;
						end else begin
							res_cnt_q  <= net_tok[NET_SLOTS].cnt;
							res_mask_q <= net_tok[NET_SLOTS].mask;
							if (net_tok[NET_SLOTS].fresh) begin
								net_count_q <= net_count_q + NETCW'(1);
							end
							state_q <= S_NODE;
						end
					end
				end
				S_NODE: begin
					if (node_tok[NODE_SLOTS].valid) begin
						if (node_tok[NODE_SLOTS].hit) begin
							res_status_q <= nntu_pkg::ST_UPDATED;
							res_first_q  <= 1'b0;
						end else if (node_tok[NODE_SLOTS].fresh) begin
							res_status_q <= nntu_pkg::ST_NEW_NODE;
							res_first_q  <= 1'b1;
							res_cnt_q    <= res_cnt_q + 7'd1;
							node_count_q <= node_count_q + NODECW'(1);
						end else begin
							res_status_q <= nntu_pkg::ST_NODE_DROP;
							res_first_q  <= 1'b0;
							drop_q       <= drop_q + 32'd1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						status         <= res_status_q;
						first_sighting <= res_first_q;
						dropped_total  <= drop_q;
						network_node_count   <= res_cnt_q;
						network_channel_mask <= res_mask_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/nntu_net_cell.sv =====
module nntu_net_cell #(
	parameter int IDX = 0,
	parameter int CW = 5,
	parameter int NCW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nntu_pkg::net_tok_t  tok_in,
	input  nntu_pkg::net_query_t qry,
	input  logic [CW-1:0]       count,
	input  logic                commit_inc,
	output nntu_pkg::net_tok_t  tok_out
);
	logic [15:0]    id_q;
	logic [3:0]     proto_q;
	logic [15:0]    mask_q;
	logic [7:0]     sig_q;
	logic [7:0]     lq_q;
	logic [NCW-1:0] cnt_q;
	logic           sel_q;
	nntu_pkg::net_tok_t tok_q;
	logic hit_here, app_here;
	nntu_pkg::net_tok_t nxt;

	assign hit_here = tok_in.valid && !tok_in.hit && (CW'(IDX) < count) && (id_q == qry.id);
	assign app_here = tok_in.valid && !tok_in.hit && (CW'(IDX) == count);

	always_comb begin
		nxt = tok_in;
		if (hit_here) begin
			nxt.hit  = 1'b1;
			nxt.mask = mask_q | qry.chbit;
			nxt.cnt  = 7'(cnt_q);
		end else if (app_here) begin
			nxt.hit   = 1'b1;
			nxt.fresh = 1'b1;
			nxt.mask  = qry.chbit;
			nxt.cnt   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			sel_q <= 1'b0;
		end else begin
			tok_q <= nxt;
			if (tok_in.valid) begin
				sel_q <= hit_here || app_here;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_here || app_here) begin
			id_q    <= qry.id;
			proto_q <= qry.proto;
			sig_q   <= qry.sig;
			lq_q    <= qry.lq;
			mask_q  <= nxt.mask;
		end
		if (app_here) begin
			cnt_q <= '0;
		end else if (commit_inc && sel_q) begin
			cnt_q <= cnt_q + NCW'(1);
		end
	end

	assign tok_out = tok_q;
endmodule

// ===== design/nntu_node_cell.sv =====
module nntu_node_cell #(
	parameter int IDX = 0,
	parameter int CW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nntu_pkg::node_tok_t   tok_in,
	input  nntu_pkg::node_query_t qry,
	input  logic [CW-1:0]         count,
	output nntu_pkg::node_tok_t   tok_out
);
	logic [15:0] net_q;
	logic [15:0] sa_q;
	logic [1:0]  flags_q;
	logic [63:0] la_q;
	logic [47:0] metrics_q;
	nntu_pkg::node_tok_t tok_q;
	logic s_hit, l_hit, hit_here, app_here;

	assign s_hit = qry.has_s && flags_q[0] && (sa_q == qry.sa);
	assign l_hit = qry.has_l && flags_q[1] && (la_q == qry.la);
	assign hit_here = tok_in.valid && !tok_in.hit && !tok_in.fresh && (CW'(IDX) < count)
		&& (net_q == qry.net) && (s_hit || l_hit);
	assign app_here = tok_in.valid && !tok_in.hit && !tok_in.fresh && (CW'(IDX) == count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.hit   <= tok_in.hit || hit_here;
			tok_q.fresh <= tok_in.fresh || app_here;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_here || app_here) begin
			metrics_q <= qry.metrics;
		end
		if (app_here) begin
			net_q   <= qry.net;
			sa_q    <= qry.sa;
			flags_q <= {qry.has_l, qry.has_s};
			la_q    <= qry.has_l ? qry.la : 64'd0;
		end
	end

	assign tok_out = tok_q;
endmodule

// ===== design/nntu_checker.sv =====
module nntu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic        first_sighting,
	input logic [31:0] dropped_total
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction taken while busy");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_sighting == (status == nntu_pkg::ST_NEW_NODE))
		else $error("first_sighting disagrees with status");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == nntu_pkg::ST_CLEARED |-> dropped_total == 32'd0)
		else $error("drop counter not cleared");
endmodule

bind network_node_table_upsert_unit nntu_checker u_nntu_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.status, .first_sighting, .dropped_total
);

// ===== tb/sv/nntu_checker.sv =====
`timescale 1ns / 100ps

module nntu_tb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [15:0] network_id,
	input  logic [4:0]  channel,
	input  logic [15:0] short_address,
	input  logic        short_present,
	input  logic [63:0] long_address,
	input  logic        long_present,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  status,
	input  logic        first_sighting,
	input  logic [31:0] dropped_total,
	input  logic [6:0]  network_node_count,
	input  logic [15:0] network_channel_mask,
	output int          fail_count,
	output int          pending_count
);
	typedef struct {
		logic [2:0]  st;
		logic        first;
		logic [31:0] drops;
		logic [6:0]  cnt;
		logic [15:0] mask;
	} sighting_result_t;

	sighting_result_t expected_results[$];

	int          nets_used;
	logic [15:0] net_id_tab [16];
	logic [15:0] net_mask_tab [16];
	int          net_nodes_tab [16];
	int          nodes_used;
	logic [15:0] node_net_tab [64];
	logic [15:0] node_sa_tab [64];
	logic        node_hs_tab [64];
	logic        node_hl_tab [64];
	logic [63:0] node_la_tab [64];
	logic [31:0] drops;

	function automatic sighting_result_t upsert_sighting();
		sighting_result_t r;
		int slot;
		bit hit;
		slot = -1;
		r = '{default: '0};
		if (operation == nntu_pkg::OP_CLEAR) begin
			nets_used = 0;
			nodes_used = 0;
			drops = 0;
			r.st = nntu_pkg::ST_CLEARED;
			return r;
		end
		for (int i = 0; i < nets_used; i++)
			if (slot < 0 && net_id_tab[i] == network_id)
				slot = i;
		if (slot < 0) begin
			if (nets_used >= 16) begin
				drops++;
				r.st = nntu_pkg::ST_NET_DROP;
				r.drops = drops;
				return r;
			end
			slot = nets_used++;
			net_id_tab[slot] = network_id;
			net_mask_tab[slot] = '0;
			net_nodes_tab[slot] = 0;
		end
		if (channel >= nntu_pkg::CH_LO && channel <= nntu_pkg::CH_HI)
			net_mask_tab[slot][channel - nntu_pkg::CH_LO] = 1'b1;
		r.mask = net_mask_tab[slot];
		hit = 0;
		for (int i = 0; i < nodes_used; i++)
			if (!hit && node_net_tab[i] == network_id &&
			    ((short_present && node_hs_tab[i] && node_sa_tab[i] == short_address) ||
			     (long_present && node_hl_tab[i] && node_la_tab[i] == long_address)))
				hit = 1;
		if (hit) begin
			r.st = nntu_pkg::ST_UPDATED;
		end else if (nodes_used >= 64) begin
			drops++;
			r.st = nntu_pkg::ST_NODE_DROP;
		end else begin
			node_net_tab[nodes_used] = network_id;
			node_sa_tab[nodes_used] = short_address;
			node_hs_tab[nodes_used] = short_present;
			node_hl_tab[nodes_used] = long_present;
			node_la_tab[nodes_used] = long_present ? long_address : '0;
			nodes_used++;
			net_nodes_tab[slot]++;
			r.st = nntu_pkg::ST_NEW_NODE;
			r.first = 1'b1;
		end
		r.cnt = net_nodes_tab[slot][6:0];
		r.drops = drops;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sighting_result_t e;
		if (!arst_n) begin
			nets_used = 0;
			nodes_used = 0;
			drops = 0;
			fail_count = 0;
			expected_results.delete();
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected transaction status=%0d", $realtime, status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st || first_sighting !== e.first ||
					    dropped_total !== e.drops || network_node_count !== e.cnt ||
					    network_channel_mask !== e.mask) begin
						$display("%0t: mismatch expected st=%0d first=%0d drops=%0d cnt=%0d mask=%h",
							$realtime, e.st, e.first, e.drops, e.cnt, e.mask);
						$display("%0t:          actual   st=%0d first=%0d drops=%0d cnt=%0d mask=%h",
							$realtime, status, first_sighting, dropped_total,
							network_node_count, network_channel_mask);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(upsert_sighting());
			pending_count = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_network_node_table_upsert_unit.sv =====
`timescale 1ns / 100ps

module tb_network_node_table_upsert_unit;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [15:0] network_id;
	logic [3:0]  protocol_code;
	logic [4:0]  channel;
	logic [15:0] short_address;
	logic        short_present;
	logic [63:0] long_address;
	logic        long_present;
	logic signed [7:0] signal_strength;
	logic [7:0]  link_quality;
	logic [31:0] seen_time;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic        first_sighting;
	logic [31:0] dropped_total;
	logic [6:0]  network_node_count;
	logic [15:0] network_channel_mask;
	int          fail_count;
	int          pending_count;
	int          idle_in_pct;
	int          stall_out_pct;

	network_node_table_upsert_unit i_dut (.*);

	nntu_tb_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_out_pct);

	task automatic send_sighting(input logic op, input logic [15:0] net,
		input logic [15:0] sa, input logic hs, input logic [63:0] la, input logic hl,
		input logic [4:0] ch);
		while ($urandom_range(99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		operation       <= op;
		network_id      <= net;
		protocol_code   <= 4'($urandom);
		channel         <= ch;
		short_address   <= sa;
		short_present   <= hs;
		long_address    <= la;
		long_present    <= hl;
		signal_strength <= 8'($urandom);
		link_quality    <= 8'($urandom);
		seen_time       <= $urandom;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [15:0] net;
		logic [15:0] sa;
		logic [63:0] la;
		net = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
		sa = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
		la = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(7));
		send_sighting($urandom_range(59) == 0 ? nntu_pkg::OP_CLEAR : nntu_pkg::OP_SIGHT,
			net, sa, 1'($urandom_range(1)), la, 1'($urandom_range(1)), 5'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = nntu_pkg::OP_SIGHT;
		network_id = '0;
		protocol_code = '0;
		channel = '0;
		short_address = '0;
		short_present = 1'b0;
		long_address = '0;
		long_present = 1'b0;
		signal_strength = '0;
		link_quality = '0;
		seen_time = '0;
		out_ready = 1'b0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sighting(nntu_pkg::OP_SIGHT, 16'h0000, 16'h0000, 1'b1, '0, 1'b0, 5'd11);
		send_sighting(nntu_pkg::OP_SIGHT, 16'h0000, 16'h0000, 1'b1, '1, 1'b1, 5'd26);
		send_sighting(nntu_pkg::OP_SIGHT, 16'h0000, 16'h1234, 1'b0, '1, 1'b1, 5'd0);
		send_sighting(nntu_pkg::OP_SIGHT, 16'hFFFF, 16'hFFFF, 1'b0, '1, 1'b0, 5'd31);
		send_sighting(nntu_pkg::OP_SIGHT, 16'hFFFF, 16'hFFFF, 1'b0, '1, 1'b0, 5'd10);
		send_sighting(nntu_pkg::OP_SIGHT, 16'hFFFF, 16'hFFFF, 1'b1, 64'h8000_0000_0000_0001,
			1'b1, 5'd27);
		send_sighting(nntu_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, '1, 1'b1, 5'd31);
		for (int i = 0; i < 18; i++)
			send_sighting(nntu_pkg::OP_SIGHT, 16'(i * 16'h0F0F), 16'($urandom), 1'b1, '0,
				1'b0, 5'(11 + i % 16));
		for (int phase = 0; phase < 4; phase++) begin
			idle_in_pct   = (phase == 1 || phase == 3) ? 83 : 0;
			stall_out_pct = (phase == 2 || phase == 3) ? 83 : 0;
			if (phase == 3) begin
				idle_in_pct = 16;
				stall_out_pct = 16;
			end
			for (int k = 0; k < 135; k++)
				send_random();
			send_sighting(nntu_pkg::OP_CLEAR, '0, '0, 1'b0, '0, 1'b0, '0);
		end
		in_valid <= 1'b0;
		idle_in_pct = 0;
		stall_out_pct = 0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#8ms;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/nntu_pkg.sv
design/nntu_net_cell.sv
design/nntu_node_cell.sv
design/network_node_table_upsert_unit.sv
design/nntu_checker.sv
tb/sv/nntu_checker.sv
tb/sv/tb_network_node_table_upsert_unit.sv
